>>> hw/rtl/tgps_pkg.sv
// Shared types, constants and helpers of the tiled grid position splitter.
`default_nettype none

package tgps_pkg;

	// Field widths fixed by the register map and the item format.
	localparam int TC_W        = 11;
	localparam int TILES_W     = 9;
	localparam int CU_W        = 8;
	localparam int REACH_W     = 10;
	localparam int CELL_W      = 10;
	localparam int OFS_W       = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 11;

	localparam int POS_BITS_DEF = 24;
	localparam int DIV_STEP     = 4;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [TC_W-1:0] TC_MAX = 11'd1024;

	// Register indexes of the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_TILE_CELLS_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_CELLS_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TILES_X      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TILES_Y      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_UNITS   = 3'd4;

	// Touched tile order: centre, N, S, W, E, NW, NE, SW, SE.
	localparam int NUM_DIRS  = 9;
	localparam int DIR_IDX_W = 4;
	localparam logic signed [OFS_W-1:0] DIR_X [NUM_DIRS] = '{
		2'sd0, 2'sd0, 2'sd0, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1};
	localparam logic signed [OFS_W-1:0] DIR_Y [NUM_DIRS] = '{
		2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd0, -2'sd1, -2'sd1, 2'sd1, 2'sd1};

	// Configuration as held in the block; tile cells and cell units are stored clamped.
	typedef struct packed {
		logic [TC_W-1:0]    tcx;
		logic [TC_W-1:0]    tcy;
		logic [TILES_W-1:0] tiles_x;
		logic [TILES_W-1:0] tiles_y;
		logic [CU_W-1:0]    cu;
	} cfg_t;

	// Which edges of the base tile the radius crosses.
	typedef struct packed {
		logic north;
		logic south;
		logic west;
		logic east;
	} cross_t;

	function automatic logic [TC_W-1:0] tc_clamp(input logic [TC_W-1:0] v);
		logic [TC_W-1:0] r;
		if (v == '0) begin
			r = TC_W'(1);
		end else if (v > TC_MAX) begin
			r = TC_MAX;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tgps_div.sv
// Pipelined unsigned restoring divider, DIV_STEP quotient bits per stage.
`default_nettype none

module tgps_div
	import tgps_pkg::*;
#(
	parameter int DW   = 23,
	parameter int VW   = 8,
	parameter int STEP = DIV_STEP
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [DW-1:0] num,
	input  wire logic [VW-1:0] den,
	output logic      [DW-1:0] quo,
	output logic      [VW-1:0] rem
);

	localparam int NSTG = (DW + STEP - 1) / STEP;
	localparam int PW   = NSTG * STEP;

	logic [PW-1:0] w_q [NSTG];
	logic [VW-1:0] r_q [NSTG];

	// The working word shifts the dividend out at the top and the quotient in at the bottom.
	for (genvar s = 0; s < NSTG; s++) begin : g_stg
		logic [PW-1:0] w_in;
		logic [PW-1:0] w_d;
		logic [VW-1:0] r_in;
		logic [VW-1:0] r_d;
		logic [VW:0]   t;

		if (s == 0) begin : g_first
			assign w_in = PW'(num);
			assign r_in = '0;
		end else begin : g_next
			assign w_in = w_q[s-1];
			assign r_in = r_q[s-1];
		end

		always_comb begin
			w_d = w_in;
			r_d = r_in;
			t   = '0;
			for (int k = 0; k < STEP; k++) begin
				t   = {r_d, w_d[PW-1]};
				w_d = {w_d[PW-2:0], 1'b0};
				if (t >= {1'b0, den}) begin
					t      = t - {1'b0, den};
					w_d[0] = 1'b1;
				end
				r_d = t[VW-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				w_q[s] <= w_d;
				r_q[s] <= r_d;
			end
		end
	end

	assign quo = w_q[NSTG-1][DW-1:0];
	assign rem = r_q[NSTG-1];

endmodule

`default_nettype wire

>>> hw/rtl/tgps_front.sv
// Front part: splits a position into base tile and cell and classifies crossed edges.
`default_nettype none

module tgps_front
	import tgps_pkg::*;
#(
	parameter int POS_BITS = POS_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cfg_t                cfg,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [POS_BITS-1:0] pos_x,
	input  wire logic [POS_BITS-1:0] pos_y,
	input  wire logic [REACH_W-1:0]  reach,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic      [POS_BITS-1:0] base_x,
	output logic      [POS_BITS-1:0] base_y,
	output logic      [CELL_W-1:0]   cell_x,
	output logic      [CELL_W-1:0]   cell_y,
	output cross_t                   edges
);

	localparam int NX   = POS_BITS - 1;
	localparam int NSTG = (NX + DIV_STEP - 1) / DIV_STEP;
	localparam int LAT  = 2 * NSTG;

	logic en;
	logic               v_q     [LAT];
	logic               neg_x_q [LAT];
	logic               neg_y_q [LAT];
	logic [REACH_W-1:0] reach_q [LAT];

	logic [NX-1:0]   ux, uy;
	logic [NX-1:0]   qa_x, qa_y, qb_x, qb_y;
	logic [TC_W-1:0] rb_x, rb_y;
	logic [TC_W-1:0] cx_w, cy_w;
	logic            neg_x, neg_y;
	logic [REACH_W-1:0] r;

	// A negative position a is divided as ~a; floor(a/b) is then ~floor(~a/b).
	assign ux = pos_x[POS_BITS-1] ? ~pos_x[NX-1:0] : pos_x[NX-1:0];
	assign uy = pos_y[POS_BITS-1] ? ~pos_y[NX-1:0] : pos_y[NX-1:0];

	assign en        = !(v_q[LAT-1] && !out_ready);
	assign in_ready  = en;
	assign out_valid = v_q[LAT-1];

	// Position / cell units first, then that quotient / tile cells.
	tgps_div #(.DW(NX), .VW(CU_W), .STEP(DIV_STEP)) u_div_ax (
		.clk(clk), .en(en), .num(ux), .den(cfg.cu), .quo(qa_x), .rem()
	);
	tgps_div #(.DW(NX), .VW(CU_W), .STEP(DIV_STEP)) u_div_ay (
		.clk(clk), .en(en), .num(uy), .den(cfg.cu), .quo(qa_y), .rem()
	);
	tgps_div #(.DW(NX), .VW(TC_W), .STEP(DIV_STEP)) u_div_bx (
		.clk(clk), .en(en), .num(qa_x), .den(cfg.tcx), .quo(qb_x), .rem(rb_x)
	);
	tgps_div #(.DW(NX), .VW(TC_W), .STEP(DIV_STEP)) u_div_by (
		.clk(clk), .en(en), .num(qa_y), .den(cfg.tcy), .quo(qb_y), .rem(rb_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) begin
				v_q[i] <= 1'b0;
			end
		end else if (en) begin
			v_q[0] <= in_valid;
			for (int i = 1; i < LAT; i++) begin
				v_q[i] <= v_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_x_q[0] <= pos_x[POS_BITS-1];
			neg_y_q[0] <= pos_y[POS_BITS-1];
			reach_q[0] <= reach;
			for (int i = 1; i < LAT; i++) begin
				neg_x_q[i] <= neg_x_q[i-1];
				neg_y_q[i] <= neg_y_q[i-1];
				reach_q[i] <= reach_q[i-1];
			end
		end
	end

	assign neg_x = neg_x_q[LAT-1];
	assign neg_y = neg_y_q[LAT-1];
	assign r     = reach_q[LAT-1];

	// For a negative position the floor remainder mirrors the one of ~a.
	always_comb begin
		base_x = neg_x ? ~{1'b0, qb_x} : {1'b0, qb_x};
		base_y = neg_y ? ~{1'b0, qb_y} : {1'b0, qb_y};
		cx_w   = neg_x ? (cfg.tcx - TC_W'(1) - rb_x) : rb_x;
		cy_w   = neg_y ? (cfg.tcy - TC_W'(1) - rb_y) : rb_y;
		cell_x = cx_w[CELL_W-1:0];
		cell_y = cy_w[CELL_W-1:0];
		edges.north = {1'b0, cell_y} < {1'b0, r};
		edges.south = ({1'b0, cell_y} + {1'b0, r}) >= cfg.tcy;
		edges.west  = {1'b0, cell_x} < {1'b0, r};
		edges.east  = ({1'b0, cell_x} + {1'b0, r}) >= cfg.tcx;
	end

endmodule

`default_nettype wire

>>> hw/rtl/tgps_queue.sv
// Small register queue between the front and back parts.
`default_nettype none

module tgps_queue
	import tgps_pkg::*;
#(
	parameter int W     = 72,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [W-1:0] in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic      [W-1:0] out_data
);

	localparam int AW = $clog2(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          push, pop;

	assign in_ready  = cnt_q != (AW + 1)'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (AW + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (AW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/tgps_back.sv
// Back part: walks the touched tiles of one item and drives the result register.
`default_nettype none

module tgps_back
	import tgps_pkg::*;
#(
	parameter int POS_BITS = POS_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cfg_t                cfg,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [POS_BITS-1:0] base_x,
	input  wire logic [POS_BITS-1:0] base_y,
	input  wire logic [CELL_W-1:0]   cell_x,
	input  wire logic [CELL_W-1:0]   cell_y,
	input  wire cross_t              edges,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic      [POS_BITS:0]   tile_x,
	output logic      [POS_BITS:0]   tile_y,
	output logic      [OFS_W-1:0]    offset_x,
	output logic      [OFS_W-1:0]    offset_y,
	output logic      [CELL_W-1:0]   cell_x_o,
	output logic      [CELL_W-1:0]   cell_y_o,
	output logic                     inside_res,
	output logic                     last
);

	localparam int TB = POS_BITS + 1;
	localparam int CW = ((TB > 10) ? TB : 10) + 1;

	logic                cur_valid_q;
	logic [NUM_DIRS-1:0] pend_q;
	logic [POS_BITS-1:0] bx_q, by_q;
	logic [CELL_W-1:0]   cx_q, cy_q;
	logic                out_valid_q;

	logic                load_out, step, pop, last_sel;
	logic [NUM_DIRS-1:0] pend_nxt, pend_new;
	logic [DIR_IDX_W-1:0] sel;
	logic signed [OFS_W-1:0] dx, dy;
	logic signed [TB-1:0] tx, ty;
	logic signed [CW-1:0] txe, tye, limx, limy;
	logic                 in_bounds;

	always_comb begin
		load_out = !out_valid_q || out_ready;
		step     = cur_valid_q && load_out;
		pend_nxt = pend_q & (pend_q - NUM_DIRS'(1));
		last_sel = pend_nxt == '0;
		pop      = in_valid && (!cur_valid_q || (step && last_sel));
		in_ready = pop;

		// Bit order follows the result order: centre, edges, then corners.
		pend_new = {edges.south & edges.east, edges.south & edges.west,
			edges.north & edges.east, edges.north & edges.west,
			edges.east, edges.west, edges.south, edges.north, 1'b1};

		sel = '0;
		for (int k = NUM_DIRS - 1; k >= 0; k--) begin
			if (pend_q[k]) begin
				sel = DIR_IDX_W'(k);
			end
		end
		dx = DIR_X[sel];
		dy = DIR_Y[sel];

		tx   = $signed({bx_q[POS_BITS-1], bx_q}) + TB'(dx);
		ty   = $signed({by_q[POS_BITS-1], by_q}) + TB'(dy);
		txe  = CW'(tx);
		tye  = CW'(ty);
		limx = $signed(CW'(cfg.tiles_x));
		limy = $signed(CW'(cfg.tiles_y));
		in_bounds = !txe[CW-1] && !tye[CW-1] && (txe < limx) && (tye < limy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				pend_q      <= pend_new;
			end else if (step) begin
				cur_valid_q <= !last_sel;
				pend_q      <= pend_nxt;
			end
			if (load_out) begin
				out_valid_q <= step;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bx_q <= base_x;
			by_q <= base_y;
			cx_q <= cell_x;
			cy_q <= cell_y;
		end
		if (step) begin
			tile_x     <= tx;
			tile_y     <= ty;
			offset_x   <= dx;
			offset_y   <= dy;
			cell_x_o   <= cx_q;
			cell_y_o   <= cy_q;
			inside_res <= in_bounds;
			last       <= last_sel;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> hw/rtl/tiled_grid_position_splitter_unit.sv
// Top level of the tiled grid position splitter: configuration, front, queue and back.
//
// Channel   Direction  Transaction
// s_axis    in         one world position and radius
// m_axis    out        one touched tile, tlast on the final one of a position
// cfg       in         one register write, index and data
//
// Results leave at one per cycle while m_axis_tready is high; a position that touches n tiles
// (1 to 9) gives n results, so the result channel sets the sustained rate.
// The front runs two chained dividers per axis, of ceil((POS_BITS-1)/4) stages each; the
// queue and the back part's item and result registers follow before m_axis.
// Reset clears all control state and sets every register to 1; no clearing pass follows.
// A stalled result register backs up the back part and the queue, and then the front
// pipeline holds and drops s_axis_tready.
`default_nettype none

module tiled_grid_position_splitter_unit
	import tgps_pkg::*;
#(
	parameter int POS_BITS = POS_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// pos_x, pos_y, reach
	input  wire logic [((2*POS_BITS+REACH_W+7)/8)*8-1:0] s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// tile_x, tile_y, offset_x, offset_y, cell_x, cell_y
	output logic [((2*(POS_BITS+1)+2*OFS_W+2*CELL_W+7)/8)*8-1:0] m_axis_tdata,
	// inside_res
	output logic                       m_axis_tuser,
	output logic                       m_axis_tlast,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int TB    = POS_BITS + 1;
	localparam int OUT_W = ((2 * TB + 2 * OFS_W + 2 * CELL_W + 7) / 8) * 8;
	localparam int QW    = 2 * POS_BITS + 2 * CELL_W + $bits(cross_t);

	cfg_t cfg_q;

	logic [POS_BITS-1:0] pos_x, pos_y;
	logic [REACH_W-1:0]  reach;

	logic                f_valid, f_ready;
	logic [POS_BITS-1:0] f_bx, f_by;
	logic [CELL_W-1:0]   f_cx, f_cy;
	cross_t              f_cross;

	logic [QW-1:0]       q_din, q_dout;
	logic                q_valid, q_ready;
	logic [POS_BITS-1:0] q_bx, q_by;
	logic [CELL_W-1:0]   q_cx, q_cy;
	cross_t              q_cross;

	logic [TB-1:0]       o_tile_x, o_tile_y;
	logic [OFS_W-1:0]    o_off_x, o_off_y;
	logic [CELL_W-1:0]   o_cell_x, o_cell_y;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tcx     <= TC_W'(1);
			cfg_q.tcy     <= TC_W'(1);
			cfg_q.tiles_x <= TILES_W'(1);
			cfg_q.tiles_y <= TILES_W'(1);
			cfg_q.cu      <= CU_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TILE_CELLS_X: cfg_q.tcx     <= tc_clamp(cfg_data);
				REG_TILE_CELLS_Y: cfg_q.tcy     <= tc_clamp(cfg_data);
				REG_TILES_X:      cfg_q.tiles_x <= cfg_data[TILES_W-1:0];
				REG_TILES_Y:      cfg_q.tiles_y <= cfg_data[TILES_W-1:0];
				REG_CELL_UNITS: begin
					// A cell size of zero counts as one unit.
					cfg_q.cu <= (cfg_data[CU_W-1:0] == '0) ? CU_W'(1) : cfg_data[CU_W-1:0];
				end
				default: ;
			endcase
		end
	end

	assign pos_x = s_axis_tdata[POS_BITS-1:0];
	assign pos_y = s_axis_tdata[2*POS_BITS-1:POS_BITS];
	assign reach = s_axis_tdata[2*POS_BITS+REACH_W-1:2*POS_BITS];

	tgps_front #(.POS_BITS(POS_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.reach     (reach),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.base_x    (f_bx),
		.base_y    (f_by),
		.cell_x    (f_cx),
		.cell_y    (f_cy),
		.edges     (f_cross)
	);

	assign q_din = {f_bx, f_by, f_cx, f_cy, f_cross};

	tgps_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (q_din),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_dout)
	);

	assign {q_bx, q_by, q_cx, q_cy, q_cross} = q_dout;

	tgps_back #(.POS_BITS(POS_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (q_valid),
		.in_ready   (q_ready),
		.base_x     (q_bx),
		.base_y     (q_by),
		.cell_x     (q_cx),
		.cell_y     (q_cy),
		.edges      (q_cross),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.tile_x     (o_tile_x),
		.tile_y     (o_tile_y),
		.offset_x   (o_off_x),
		.offset_y   (o_off_y),
		.cell_x_o   (o_cell_x),
		.cell_y_o   (o_cell_y),
		.inside_res (m_axis_tuser),
		.last       (m_axis_tlast)
	);

	assign m_axis_tdata = OUT_W'({o_cell_y, o_cell_x, o_off_y, o_off_x, o_tile_y, o_tile_x});

endmodule

`default_nettype wire
